@@ hdl/x86alu_pkg.sv @@
// Shared types, codes and helper functions for the x86 integer ALU.
package x86alu_pkg;

    // Operation codes carried on the op field.
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_ADC = 4'd1,
        OP_SUB = 4'd2,
        OP_SBB = 4'd3,
        OP_AND = 4'd4,
        OP_OR  = 4'd5,
        OP_XOR = 4'd6,
        OP_SHL = 4'd7,
        OP_SHR = 4'd8,
        OP_SAR = 4'd9
    } t_alu_op;

    // Operand size codes; the unused code behaves as 32 bits.
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned OP_W    = 4;
    localparam int unsigned SIZE_W  = 2;
    localparam int unsigned SHAMT_W = 5;

    localparam logic [DATA_W-1:0] MASK_8  = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_32 = 32'hFFFF_FFFF;

    // The kept flag word.
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic pf;
        logic cf;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{of: 1'b0, sf: 1'b0, zf: 1'b0, pf: 1'b0, cf: 1'b0};

    // Mask that keeps the bits of the given operand size.
    function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] m;
        unique case (size)
            SIZE_8:  m = MASK_8;
            SIZE_16: m = MASK_16;
            default: m = MASK_32;
        endcase
        return m;
    endfunction

    // Most significant bit of a value at the given operand size.
    function automatic logic top_bit(input logic [DATA_W-1:0] v,
                                     input logic [SIZE_W-1:0] size);
        logic b;
        unique case (size)
            SIZE_8:  b = v[7];
            SIZE_16: b = v[15];
            default: b = v[31];
        endcase
        return b;
    endfunction

    // Bit just above the operand size in a 33-bit value (carry position).
    function automatic logic carry_bit(input logic [DATA_W:0] v,
                                       input logic [SIZE_W-1:0] size);
        logic b;
        unique case (size)
            SIZE_8:  b = v[8];
            SIZE_16: b = v[16];
            default: b = v[32];
        endcase
        return b;
    endfunction

endpackage

@@ hdl/x86alu_core.sv @@
// Combinational datapath of the ALU: result and next flag word for one item.
module x86alu_core (
    input  logic [x86alu_pkg::OP_W-1:0]   i_op,
    input  logic [x86alu_pkg::DATA_W-1:0] i_src_operand,
    input  logic [x86alu_pkg::DATA_W-1:0] i_dest_operand,
    input  logic [x86alu_pkg::SIZE_W-1:0] i_size_code,
    input  x86alu_pkg::t_flags            i_flags,
    output logic [x86alu_pkg::DATA_W-1:0] o_result_value,
    output x86alu_pkg::t_flags            o_flags
);
    import x86alu_pkg::*;

    t_alu_op               op;
    logic [DATA_W-1:0]     mask;
    logic [DATA_W-1:0]     a;
    logic [DATA_W-1:0]     b;
    logic                  cin;
    logic [SHAMT_W-1:0]    shamt;
    logic [DATA_W:0]       sum;
    logic [DATA_W-1:0]     diff;
    logic                  borrow;
    logic [DATA_W:0]       shl_wide;
    logic [DATA_W:0]       shr_wide;
    logic [DATA_W-1:0]     sext;
    logic signed [DATA_W:0] sar_wide;
    logic [DATA_W-1:0]     res;
    logic                  cf_new;
    logic                  of_new;
    logic                  upd_cf;
    logic                  upd_of;
    logic                  upd_pzs;

    // Operands masked to the operand size.
    assign op    = t_alu_op'(i_op);
    assign mask  = size_mask(i_size_code);
    assign a     = i_dest_operand & mask;
    assign b     = i_src_operand & mask;
    assign shamt = i_src_operand[SHAMT_W-1:0];
    assign cin   = ((op == OP_ADC) || (op == OP_SBB)) ? i_flags.cf : 1'b0;

    // Adder and subtractor, both with the carry or borrow input.
    assign sum    = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
    assign diff   = (a - b - {{(DATA_W-1){1'b0}}, cin}) & mask;
    assign borrow = ({1'b0, a} < ({1'b0, b} + {{DATA_W{1'b0}}, cin}));

    // Shifters; an extra bit catches the last bit shifted out.
    assign shl_wide = {1'b0, a} << shamt;
    assign shr_wide = {a, 1'b0} >> shamt;
    assign sext     = top_bit(a, i_size_code) ? (a | ~mask) : a;
    assign sar_wide = $signed({sext, 1'b0}) >>> shamt;

    // Select the result and which flags the operation writes.
    always_comb begin
        res     = a;
        cf_new  = i_flags.cf;
        of_new  = i_flags.of;
        upd_cf  = 1'b0;
        upd_of  = 1'b0;
        upd_pzs = 1'b0;
        unique case (op)
            OP_ADD, OP_ADC: begin
                res     = sum[DATA_W-1:0] & mask;
                cf_new  = carry_bit(sum, i_size_code);
                of_new  = top_bit(~(a ^ b) & (a ^ (sum[DATA_W-1:0] & mask)), i_size_code);
                upd_cf  = 1'b1;
                upd_of  = 1'b1;
                upd_pzs = 1'b1;
            end
            OP_SUB, OP_SBB: begin
                res     = diff;
                cf_new  = borrow;
                of_new  = top_bit((a ^ b) & (a ^ diff), i_size_code);
                upd_cf  = 1'b1;
                upd_of  = 1'b1;
                upd_pzs = 1'b1;
            end
            OP_AND, OP_OR, OP_XOR: begin
                if (op == OP_AND) begin
                    res = a & b;
                end else if (op == OP_OR) begin
                    res = a | b;
                end else begin
                    res = a ^ b;
                end
                cf_new  = 1'b0;
                of_new  = 1'b0;
                upd_cf  = 1'b1;
                upd_of  = 1'b1;
                upd_pzs = 1'b1;
            end
            OP_SHL: begin
                if (shamt != '0) begin
                    res     = shl_wide[DATA_W-1:0] & mask;
                    cf_new  = carry_bit(shl_wide, i_size_code);
                    upd_cf  = 1'b1;
                    upd_pzs = 1'b1;
                end
            end
            OP_SHR: begin
                if (shamt != '0) begin
                    res     = shr_wide[DATA_W:1];
                    cf_new  = shr_wide[0];
                    upd_cf  = 1'b1;
                    upd_pzs = 1'b1;
                end
            end
            OP_SAR: begin
                if (shamt != '0) begin
                    res     = sar_wide[DATA_W:1] & mask;
                    cf_new  = sar_wide[0];
                    upd_cf  = 1'b1;
                    upd_pzs = 1'b1;
                end
            end
            default: begin
                // Undefined op codes pass the operand and keep the flags.
                res = a;
            end
        endcase
    end

    // Assemble the next flag word.
    always_comb begin
        o_flags = i_flags;
        if (upd_cf) begin
            o_flags.cf = cf_new;
        end
        if (upd_of) begin
            o_flags.of = of_new;
        end
        if (upd_pzs) begin
            o_flags.pf = ~(^res[7:0]);
            o_flags.zf = (res == '0);
            o_flags.sf = top_bit(res, i_size_code);
        end
    end

    assign o_result_value = res;

endmodule

@@ hdl/x86_integer_alu_with_flags.sv @@
// Top level of the x86 integer ALU: input register, datapath, result register, flags.
//
// The block takes one item per clock cycle while the output is not stalled. An
// accepted item is captured in the input register, passes the datapath and lands in
// the result register together with the updated CF, PF, ZF, SF and OF. The flag
// word register is written on the same edge as the result register, so an add with
// carry or subtract with borrow in the very next item already sees the new CF.
// Back-pressure on the output stalls the result register and any item waiting in
// the input register in place; nothing is dropped or repeated.
module x86_integer_alu_with_flags (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [x86alu_pkg::OP_W-1:0]   i_op,
    input  logic [x86alu_pkg::DATA_W-1:0] i_src_operand,
    input  logic [x86alu_pkg::DATA_W-1:0] i_dest_operand,
    input  logic [x86alu_pkg::SIZE_W-1:0] i_size_code,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [x86alu_pkg::DATA_W-1:0] o_result_value,
    output logic                          o_carry_flag,
    output logic                          o_parity_flag,
    output logic                          o_zero_flag,
    output logic                          o_sign_flag,
    output logic                          o_overflow_flag
);
    import x86alu_pkg::*;

    logic                r_in_valid;
    logic [OP_W-1:0]     r_op;
    logic [DATA_W-1:0]   r_src;
    logic [DATA_W-1:0]   r_dest;
    logic [SIZE_W-1:0]   r_size;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_result;
    t_flags              r_out_flags;
    t_flags              r_flags;
    t_flags              n_flags;
    logic [DATA_W-1:0]   n_result;
    logic                out_free;
    logic                advance;
    logic                in_take;

    // Handshake: the result register frees when empty or taken.
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;
    assign in_take  = i_valid && o_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (in_take) begin
            r_op   <= i_op;
            r_src  <= i_src_operand;
            r_dest <= i_dest_operand;
            r_size <= i_size_code;
        end
    end

    // Datapath for the item in the input register.
    x86alu_core u_core (
        .i_op           (r_op),
        .i_src_operand  (r_src),
        .i_dest_operand (r_dest),
        .i_size_code    (r_size),
        .i_flags        (r_flags),
        .o_result_value (n_result),
        .o_flags        (n_flags)
    );

    // Result register and kept flag word, written together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= FLAGS_RESET;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_flags <= n_flags;
            end
        end
        if (advance) begin
            r_result    <= n_result;
            r_out_flags <= n_flags;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_value  = r_result;
    assign o_carry_flag    = r_out_flags.cf;
    assign o_parity_flag   = r_out_flags.pf;
    assign o_zero_flag     = r_out_flags.zf;
    assign o_sign_flag     = r_out_flags.sf;
    assign o_overflow_flag = r_out_flags.of;

    // The flag word only changes when an item moves into the result register.
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_flags))
        else $error("flag word changed without an item advancing");

    // While a result is valid, the delivered flags equal the current kept flag word.
    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_flags == r_flags))
        else $error("output flags differ from kept flag word");

    // A result that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=>
            (r_out_valid && $stable(r_result) && $stable(r_out_flags)))
        else $error("result changed while waiting to be taken");

    // An item waiting in the input register holds while the result register is stalled.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_op) && $stable(r_dest)))
        else $error("input register lost an item during a stall");

endmodule
